/* rtl/dgsp_pkg.sv */
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types and constants for the shortest-path block.
// ----------------------------------------------------------------------------
package dgsp_pkg;

  localparam int unsigned MaxNodesDef = 128;
  localparam int unsigned CostBitsDef = 20;
  localparam int unsigned NodeBits    = 7;
  localparam int unsigned CountBits   = 8;
  localparam int unsigned CostBits    = 20;
  localparam int unsigned DistBits    = 27;
  localparam int unsigned NodeCountRst = 128;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_ADD   = 1'b1
  } opcode_e;

  localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;

  // controller to datapath commands
  typedef struct packed {
    logic clr_wr;     // write zero to matrix at clear address
    logic load_item;  // capture incoming item
    logic add_rd_ab;  // read matrix entry a,b
    logic add_wr_ab;  // conditional write a,b
    logic add_rd_ba;
    logic add_wr_ba;
    logic q_init;     // reset per-node state
    logic scan_clr;   // start a min scan
    logic scan_step;  // evaluate node scan index
    logic settle;     // settle the best node
    logic relax_rd;   // read matrix row entry
    logic relax_step; // relax with returned entry
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;
  } dgsp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_last;   // counter at final index
    logic have_best;
    logic q_valid;    // query endpoints are in range
    logic is_add;
    logic add_ok;
  } dgsp_sts_t;

endpackage

/* rtl/dgsp_if.sv */
// ----------------------------------------------------------------------------
// dgsp_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface dgsp_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dgsp_ram.sv */
// ----------------------------------------------------------------------------
// dgsp_ram
// Simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
module dgsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // a read of the address being written returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/dgsp_datapath.sv */
// ----------------------------------------------------------------------------
// dgsp_datapath
// Cost matrix, per-node distance store and scan/relax arithmetic.
// ----------------------------------------------------------------------------
module dgsp_datapath import dgsp_pkg::*; #(
  parameter int unsigned MaxNodes = MaxNodesDef,
  parameter int unsigned CBits    = CostBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dgsp_cmd_t         cmd_i,
  output dgsp_sts_t         sts_o,
  input  logic [CountBits-1:0] node_count_i,
  input  logic              in_op_i,
  input  logic [NodeBits-1:0] in_a_i,
  input  logic [NodeBits-1:0] in_b_i,
  input  logic [CostBits-1:0] in_cost_i,
  output logic              found_o,
  output logic [DistBits-1:0] distance_o
);
  localparam int unsigned IdxW  = $clog2(MaxNodes);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned DW    = DistBits + 1;
  localparam int unsigned CntW  = IdxW + 1;

  logic [CntW-1:0]  cnt_q;
  logic [AddrW-1:0] clr_addr_q;
  logic [CntW-1:0]  n_eff;
  logic             op_q;
  logic [CntW-1:0]  a_q, b_q;
  logic [CBits-1:0] cost_q;

  logic [IdxW-1:0]  best_q;
  logic [DW-1:0]    best_d_q;
  logic             have_q;
  logic             scan_ok_q;
  logic [IdxW-1:0]  scan_idx_q;

  logic [MaxNodes-1:0] settled_q, reached_q;

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [CBits-1:0] ram_wd, ram_rd;
  logic [IdxW-1:0]  rel_idx_q;

  logic             dist_we;
  logic [IdxW-1:0]  dist_waddr, dist_raddr;
  logic [DW-1:0]    dist_wd, dist_rd;
  logic             relax_ok;

  logic [IdxW-1:0]  ci;
  logic [DW-1:0]    nd;
  logic [DW:0]      nd_sum;

  assign ci = cnt_q[IdxW-1:0];

  // effective node count saturates at MaxNodes
  always_comb begin
    if ({1'b0, node_count_i} > (CountBits+1)'(MaxNodes)) n_eff = CntW'(MaxNodes);
    else n_eff = CntW'(node_count_i);
  end

  dgsp_ram #(.Width(CBits), .Depth(1 << AddrW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wd),
    .raddr_i (ram_addr),
    .rdata_o (ram_rd)
  );

  // matrix address and write control
  always_comb begin
    ram_we   = 1'b0;
    ram_wd   = cost_q;
    ram_addr = {ci, ci};
    if (cmd_i.clr_wr) begin
      ram_we   = 1'b1;
      ram_wd   = '0;
      ram_addr = clr_addr_q;
    end else if (cmd_i.add_rd_ab || cmd_i.add_wr_ab) begin
      ram_addr = {a_q[IdxW-1:0], b_q[IdxW-1:0]};
      ram_we   = cmd_i.add_wr_ab && (ram_rd == '0 || cost_q < ram_rd);
    end else if (cmd_i.add_rd_ba || cmd_i.add_wr_ba) begin
      ram_addr = {b_q[IdxW-1:0], a_q[IdxW-1:0]};
      ram_we   = cmd_i.add_wr_ba && (ram_rd == '0 || cost_q < ram_rd);
    end else if (cmd_i.relax_rd) begin
      ram_addr = {best_q, ci};
    end
  end

  assign nd_sum = {1'b0, best_d_q} + (DW+1)'(ram_rd);
  assign nd     = nd_sum[DW] ? {DW{1'b1}} : nd_sum[DW-1:0];

  // relax hits when the returned entry is an edge to an open, improvable node
  assign relax_ok = cmd_i.relax_step && ram_rd != '0 && !settled_q[rel_idx_q] &&
                    (!reached_q[rel_idx_q] || nd < dist_rd);

  // distance store: the scan and relax passes read at the counter, otherwise
  // the target is read so its distance is ready for the result
  assign dist_raddr = (cmd_i.scan_step || cmd_i.relax_rd) ? ci : b_q[IdxW-1:0];

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = rel_idx_q;
    dist_wd    = nd;
    if (cmd_i.q_init) begin
      dist_we    = 1'b1;
      dist_waddr = a_q[IdxW-1:0];
      dist_wd    = '0;
    end else if (relax_ok) begin
      dist_we    = 1'b1;
    end
  end

  dgsp_ram #(.Width(DW), .Depth(MaxNodes)) u_dist (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wd),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rd)
  );

  // item capture, counter and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      clr_addr_q <= '0;
      have_q     <= 1'b0;
      best_q     <= '0;
      best_d_q   <= '0;
      scan_ok_q  <= 1'b0;
      scan_idx_q <= '0;
      rel_idx_q  <= '0;
      settled_q  <= '0;
      reached_q  <= '0;
      found_o    <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.clr_wr) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.q_init) begin
        settled_q <= '0;
        reached_q <= MaxNodes'(1) << a_q[IdxW-1:0];
      end
      // scan candidate is judged in the next cycle, once its distance is read
      scan_ok_q  <= cmd_i.scan_step && reached_q[ci] && !settled_q[ci];
      scan_idx_q <= ci;
      if (cmd_i.scan_clr) have_q <= 1'b0;
      else if (scan_ok_q && (!have_q || dist_rd < best_d_q)) begin
        have_q   <= 1'b1;
        best_q   <= scan_idx_q;
        best_d_q <= dist_rd;
      end
      if (cmd_i.settle) settled_q[best_q] <= 1'b1;
      if (cmd_i.relax_rd) rel_idx_q <= ci;
      if (relax_ok) reached_q[rel_idx_q] <= 1'b1;
      if (cmd_i.out_load) begin
        found_o <= sts_o.q_valid && reached_q[b_q[IdxW-1:0]];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= in_op_i;
      a_q    <= CntW'(in_a_i);
      b_q    <= CntW'(in_b_i);
      cost_q <= CBits'(in_cost_i);
    end
    if (cmd_i.out_load) begin
      if (sts_o.q_valid && reached_q[b_q[IdxW-1:0]]) begin
        distance_o <= dist_rd[DW-1] ? {DistBits{1'b1}} : dist_rd[DistBits-1:0];
      end else begin
        distance_o <= '0;
      end
    end
  end

  assign sts_o.cnt_last  = cmd_i.clr_wr ? (clr_addr_q == {AddrW{1'b1}})
                                        : (cnt_q + 1'b1 >= n_eff);
  assign sts_o.have_best = have_q;
  assign sts_o.q_valid   = (a_q < n_eff) && (b_q < n_eff);
  assign sts_o.is_add    = op_q;
  assign sts_o.add_ok    = (a_q < CntW'(MaxNodes)) && (b_q < CntW'(MaxNodes))
                           && (cost_q != '0);

  // a settled node is always reached
  a_settled_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settled_q & ~reached_q) == '0) else $error("settled node not reached");
  // the node just settled was a reached one
  a_settle_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.settle |-> have_q && reached_q[best_q]) else $error("settle without best");
endmodule

/* rtl/dgsp_ctrl.sv */
// ----------------------------------------------------------------------------
// dgsp_ctrl
// Sequencer: matrix clear, edge insert and Dijkstra rounds.
// ----------------------------------------------------------------------------
module dgsp_ctrl import dgsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dgsp_sts_t sts_i,
  output dgsp_cmd_t cmd_o
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_ADD_AB, S_ADD_RB, S_ADD_BA,
    S_INIT, S_SCAN, S_SCAN_END, S_PICK, S_REL_RD, S_REL_LAST, S_DONE, S_OUT
  } state_e;

  state_e state_q;
  logic   rel_pend_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_CLEAR:  begin cmd_o.clr_wr = 1'b1; cmd_o.cnt_inc = 1'b1; end
      S_IDLE:   cmd_o.load_item = in_valid_i;
      S_DECODE: cmd_o.add_rd_ab = 1'b1;
      S_ADD_AB: cmd_o.add_wr_ab = sts_i.add_ok;
      S_ADD_RB: cmd_o.add_rd_ba = 1'b1;
      S_ADD_BA: cmd_o.add_wr_ba = sts_i.add_ok;
      S_INIT:   begin cmd_o.q_init = 1'b1; cmd_o.cnt_clr = 1'b1; cmd_o.scan_clr = 1'b1; end
      S_SCAN:   begin cmd_o.scan_step = 1'b1; cmd_o.cnt_inc = 1'b1; end
      S_SCAN_END: ;  // last candidate is judged here
      S_PICK:   begin cmd_o.settle = sts_i.have_best; cmd_o.cnt_clr = 1'b1; end
      S_REL_RD: begin
        cmd_o.relax_rd = 1'b1; cmd_o.cnt_inc = 1'b1; cmd_o.relax_step = rel_pend_q;
      end
      S_REL_LAST: begin cmd_o.relax_step = 1'b1; cmd_o.cnt_clr = 1'b1; cmd_o.scan_clr = 1'b1; end
      S_DONE:   cmd_o.out_load = 1'b1;
      S_OUT:    ;
      default:  ;
    endcase
    if (state_q == S_SCAN && sts_i.cnt_last) cmd_o.cnt_inc = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      rel_pend_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR:  if (sts_i.cnt_last) state_q <= S_IDLE;
        S_IDLE:   if (in_valid_i) state_q <= S_DECODE;
        S_DECODE: state_q <= sts_i.is_add ? S_ADD_AB
                           : (sts_i.q_valid ? S_INIT : S_DONE);
        S_ADD_AB: state_q <= S_ADD_RB;
        S_ADD_RB: state_q <= S_ADD_BA;
        S_ADD_BA: state_q <= S_IDLE;
        S_INIT:   state_q <= S_SCAN;
        S_SCAN:   if (sts_i.cnt_last) state_q <= S_SCAN_END;
        S_SCAN_END: state_q <= S_PICK;
        S_PICK: begin
          rel_pend_q <= 1'b0;
          state_q <= sts_i.have_best ? S_REL_RD : S_DONE;
        end
        S_REL_RD: begin
          rel_pend_q <= 1'b1;
          if (sts_i.cnt_last) state_q <= S_REL_LAST;
        end
        S_REL_LAST: state_q <= S_SCAN;
        S_DONE:   state_q <= S_OUT;
        S_OUT:    if (out_ready_i) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // no item is taken while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  // a result follows only a query decision
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE) else $error("bad output entry");
  // the relax pass never settles
  a_relax_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.relax_step |-> !cmd_o.settle) else $error("settle during relax");
endmodule

/* rtl/dynamic_graph_shortest_path.sv */
// ----------------------------------------------------------------------------
// dynamic_graph_shortest_path
// Undirected weighted graph store with single-pair shortest-path queries.
// ----------------------------------------------------------------------------
// After reset the block clears its cost matrix, one entry per cycle, before
// taking items. An add-edge transaction makes two read-compare-write passes
// on the matrix RAM. A query with n = node_count runs Dijkstra rounds until
// no open node is left: each round scans n distances for the minimum, then
// reads one matrix row, one entry a cycle. A query with an endpoint outside
// the node count answers without a search.
// One transaction is in flight at a time; the result register holds until
// taken, and the next item is accepted in the cycle after.
// Item payload, MSB first: opcode, node_a, node_b, edge_cost.
// Result payload, MSB first: found, distance.
module dynamic_graph_shortest_path import dgsp_pkg::*; #(
  parameter int unsigned MaxNodes = MaxNodesDef,
  parameter int unsigned CBits    = CostBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dgsp_if.sink             in_if,
  dgsp_if.source           out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  dgsp_cmd_t cmd;
  dgsp_sts_t sts;
  logic [CountBits-1:0] node_count_q;
  logic                 found;
  logic [DistBits-1:0]  distance;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) node_count_q <= CountBits'(NodeCountRst);
    else if (psel && penable && pwrite && paddr[2] == 1'b0 &&
             paddr[1:0] == ADDR_NODE_COUNT)
      node_count_q <= pwdata[CountBits-1:0];
  end
  assign prdata = (paddr == 3'd0) ? {{(32-CountBits){1'b0}}, node_count_q} : '0;

  dgsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dgsp_datapath #(.MaxNodes(MaxNodes), .CBits(CBits)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .node_count_i (node_count_q),
    .in_op_i      (in_if.data[34]),
    .in_a_i       (in_if.data[33:27]),
    .in_b_i       (in_if.data[26:20]),
    .in_cost_i    (in_if.data[19:0]),
    .found_o      (found),
    .distance_o   (distance)
  );

  assign out_if.data = {found, distance};
endmodule

/* test/tb_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checker
// Watches the item and result channels and the register port, keeps its own
// copy of the graph, and predicts every query result by running Dijkstra over
// the stored cost matrix. Results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_checker import dgsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [34:0] in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [27:0] out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          pending_o,
  output int          errors_o
);

  localparam int Nodes = 128;
  localparam longint DistSat = (longint'(1) << DistBits) - 1;

  typedef struct {
    logic        found;
    logic [26:0] path_len;
  } path_result_t;

  logic [CostBits-1:0] cost_mat [Nodes][Nodes];
  logic [7:0]          node_cnt;
  path_result_t        path_q[$];
  int                  errors;

  assign pending_o = path_q.size();
  assign errors_o  = errors;

  // dense Dijkstra over the first node_cnt nodes
  function automatic path_result_t shortest_path(int src, int dst);
    path_result_t res;
    longint       node_d [Nodes];
    bit           done [Nodes];
    bit           seen [Nodes];
    int           n;
    int           best;
    longint       nd;
    res.found    = 1'b0;
    res.path_len = '0;
    n = (node_cnt > Nodes) ? Nodes : int'(node_cnt);
    if (src >= n || dst >= n) return res;
    for (int i = 0; i < n; i++) begin
      node_d[i] = 0;
      done[i] = 0;
      seen[i] = 0;
    end
    seen[src] = 1;
    for (int r = 0; r < n; r++) begin
      best = -1;
      for (int i = 0; i < n; i++) begin
        if (seen[i] && !done[i] && (best < 0 || node_d[i] < node_d[best])) best = i;
      end
      if (best < 0) break;
      done[best] = 1;
      for (int i = 0; i < n; i++) begin
        if (cost_mat[best][i] != 0 && !done[i]) begin
          nd = node_d[best] + longint'(cost_mat[best][i]);
          if (!seen[i] || nd < node_d[i]) begin
            node_d[i] = nd;
            seen[i] = 1;
          end
        end
      end
    end
    if (seen[dst]) begin
      res.found    = 1'b1;
      res.path_len = (node_d[dst] > DistSat) ? DistSat[26:0] : node_d[dst][26:0];
    end
    return res;
  endfunction

  // keep the cheaper of the stored and the new edge, both directions
  function automatic void add_edge(int a, int b, logic [CostBits-1:0] c);
    if (c == 0) return;
    if (cost_mat[a][b] == 0 || c < cost_mat[a][b]) cost_mat[a][b] = c;
    if (cost_mat[b][a] == 0 || c < cost_mat[b][a]) cost_mat[b][a] = c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    path_result_t got;
    path_result_t exp_r;
    if (!rst_ni) begin
      node_cnt = NodeCountRst[7:0];
      errors   = 0;
      path_q.delete();
      for (int i = 0; i < Nodes; i++)
        for (int j = 0; j < Nodes; j++) cost_mat[i][j] = '0;
    end else begin
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == {1'b0, ADDR_NODE_COUNT})
        node_cnt = pwdata_i[7:0];
      // result transactions
      if (out_valid_i && out_ready_i) begin
        got.found    = out_data_i[27];
        got.path_len = out_data_i[26:0];
        if (path_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result found=%0b dist=%0d", $time, got.found,
                   got.path_len);
        end else begin
          exp_r = path_q.pop_front();
          if (got.found !== exp_r.found) begin
            errors++;
            $display("%0t: found mismatch expected %0b actual %0b", $time,
                     exp_r.found, got.found);
          end
          if (got.path_len !== exp_r.path_len) begin
            errors++;
            $display("%0t: distance mismatch expected %0d actual %0d", $time,
                     exp_r.path_len, got.path_len);
          end
        end
      end
      // item transactions
      if (in_valid_i && in_ready_i) begin
        if (opcode_e'(in_data_i[34]) == OP_ADD)
          add_edge(int'(in_data_i[33:27]), int'(in_data_i[26:20]), in_data_i[19:0]);
        else
          path_q.push_back(shortest_path(int'(in_data_i[33:27]),
                                         int'(in_data_i[26:20])));
      end
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives add-edge and query transactions into the shortest-path block over
// several node-count settings, with random gaps on both channels and one long
// output stall. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import dgsp_pkg::*;

  localparam longint CycleLimit = 4_000_000;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          pending, errors;
  bit          calm;
  bit          done_stim;
  int          n_items, n_queries, n_settings;
  longint      cycles;

  dgsp_if #(.Width(35)) in_if ();
  dgsp_if #(.Width(28)) out_if ();

  dynamic_graph_shortest_path u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  tb_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_if.valid),
    .in_ready_i (in_if.ready),
    .in_data_i  (in_if.data),
    .out_valid_i(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_data_i (out_if.data),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int gap_draw();
    return calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  // result side: random backpressure, one long hold-off
  initial begin
    int gap;
    int taken;
    out_if.ready = 1'b0;
    taken = 0;
    @(posedge rst_n);
    forever begin
      gap = gap_draw();
      if (taken == 6) gap = 400;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      taken++;
    end
  end

  task automatic send_item(opcode_e op, int a, int b, int cost);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {op, a[6:0], b[6:0], cost[19:0]};
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    n_items++;
    if (op == OP_QUERY) n_queries++;
  endtask

  // wait for all results, let a trailing add-edge finish, then write
  task automatic set_node_count(int value);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {1'b0, ADDR_NODE_COUNT};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  function automatic int pick_node(int n);
    return ($urandom_range(0, 99) < 90) ? int'($urandom_range(0, n - 1))
                                        : int'($urandom_range(0, 127));
  endfunction

  task automatic send_random(int n, int count, int query_pct);
    int r;
    int cost;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) cost = 0;
      else if (r < 20) cost = 20'hFFFFF;
      else if (r < 30) cost = int'($urandom() & 32'hFFFFF);
      else cost = $urandom_range(1, 50);
      if ($urandom_range(0, 99) < query_pct)
        send_item(OP_QUERY, pick_node(n), pick_node(n), int'($urandom()));
      else
        send_item(OP_ADD, pick_node(n), pick_node(n), cost);
    end
  endtask

  initial begin
    int counts [6];
    counts = '{8, 1, 16, 12, 128, 5};
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    calm = 1'b0;
    n_items = 0; n_queries = 0; n_settings = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty graph, parallel edges, extreme cost, self loop, zero cost
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, 127, 20'hFFFFF);
    send_item(OP_ADD, 0, 1, 5);
    send_item(OP_ADD, 1, 0, 3);
    send_item(OP_ADD, 1, 2, 20'hFFFFF);
    send_item(OP_ADD, 3, 3, 7);
    send_item(OP_ADD, 2, 3, 0);
    send_item(OP_ADD, 127, 126, 1);
    send_item(OP_ADD, 126, 0, 20'h80000);
    send_item(OP_QUERY, 0, 2, 0);
    send_item(OP_QUERY, 2, 0, 0);
    send_item(OP_QUERY, 3, 3, 0);
    send_item(OP_QUERY, 127, 2, 0);
    send_item(OP_QUERY, 1, 3, 0);
    // node count zero: nothing is reachable
    set_node_count(0);
    send_item(OP_QUERY, 0, 0, 0);
    // above the maximum saturates
    set_node_count(255);
    send_item(OP_QUERY, 0, 127, 0);
    // tiny graph: endpoints beyond the count
    set_node_count(2);
    send_item(OP_ADD, 5, 6, 9);
    send_item(OP_QUERY, 0, 1, 0);
    send_item(OP_QUERY, 0, 5, 0);
    send_item(OP_QUERY, 5, 6, 0);

    // random phases
    foreach (counts[p]) begin
      set_node_count(counts[p]);
      calm = (p == 2);
      if (counts[p] == 128) send_random(128, 10, 25);
      else send_random(counts[p], 16, 40);
    end
    calm = 1'b0;

    in_if.valid <= 1'b0;
    done_stim = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d transactions (%0d queries) across %0d node-count settings,",
             n_items, n_queries, n_settings + 1);
    $display("including empty, single-node and full-size graphs under backpressure.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
